>>> sv/tlseq_pkg.sv
// Package for the two-road traffic light sequencer: types, codes, phase tables.
package tlseq_pkg;

	// Field widths
	localparam int DUR_W         = 16;
	localparam int BLINK_W       = 10;
	localparam int DISP_W        = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int PHASE_W       = 3;
	localparam int COUNT_BITS_DEF = 16;

	// Register reset values
	localparam logic [DUR_W-1:0]   TURN_TICKS_RST   = 16'd10000;
	localparam logic [DUR_W-1:0]   NGREEN_TICKS_RST = 16'd10000;
	localparam logic [DUR_W-1:0]   RGREEN_TICKS_RST = 16'd30000;
	localparam logic [DUR_W-1:0]   AMBER_TICKS_RST  = 16'd3000;
	localparam logic [DUR_W-1:0]   ALLRED_TICKS_RST = 16'd1000;
	localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST = 10'd125;
	localparam logic [DISP_W-1:0]  DISP_PERIOD_RST  = 8'd15;

	// Last phase of each cycle
	localparam logic [PHASE_W-1:0] LAST_PHASE_NORMAL = 3'd5;
	localparam logic [PHASE_W-1:0] LAST_PHASE_RUSH   = 3'd7;

	typedef enum logic [1:0] {
		ASP_RED   = 2'd0,
		ASP_AMBER = 2'd1,
		ASP_GREEN = 2'd2,
		ASP_TURN  = 2'd3
	} aspect_t;

	typedef enum logic [2:0] {
		SEL_TURN   = 3'd0,
		SEL_NGREEN = 3'd1,
		SEL_RGREEN = 3'd2,
		SEL_AMBER  = 3'd3,
		SEL_ALLRED = 3'd4
	} dur_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TURN_TICKS   = 3'd0,
		CFG_NGREEN_TICKS = 3'd1,
		CFG_RGREEN_TICKS = 3'd2,
		CFG_AMBER_TICKS  = 3'd3,
		CFG_ALLRED_TICKS = 3'd4,
		CFG_BLINK_PERIOD = 3'd5,
		CFG_DISP_PERIOD  = 3'd6
	} cfg_idx_t;

	// One result as it leaves the block
	typedef struct packed {
		logic                lamp_red;
		logic                lamp_amber;
		logic                lamp_green;
		logic [1:0]          north_south_aspect;
		logic [1:0]          east_west_aspect;
		logic [PHASE_W-1:0]  phase_index;
		logic                rush_active;
	} result_t;

	// North-south aspect by mode and phase
	function automatic aspect_t ns_aspect(input logic rush, input logic [PHASE_W-1:0] ph);
		aspect_t a;
		a = ASP_RED;
		if (rush) begin
			case (ph)
				3'd4:    a = ASP_TURN;
				3'd5:    a = ASP_GREEN;
				3'd6:    a = ASP_AMBER;
				default: a = ASP_RED;
			endcase
		end else begin
			case (ph)
				3'd3:    a = ASP_TURN;
				3'd4:    a = ASP_GREEN;
				3'd5:    a = ASP_AMBER;
				default: a = ASP_RED;
			endcase
		end
		return a;
	endfunction

	// East-west aspect is the same in both modes
	function automatic aspect_t ew_aspect(input logic [PHASE_W-1:0] ph);
		aspect_t a;
		case (ph)
			3'd0:    a = ASP_TURN;
			3'd1:    a = ASP_GREEN;
			3'd2:    a = ASP_AMBER;
			default: a = ASP_RED;
		endcase
		return a;
	endfunction

	// Which duration register a phase loads
	function automatic dur_sel_t dur_select(input logic rush, input logic [PHASE_W-1:0] ph);
		dur_sel_t s;
		if (rush) begin
			case (ph)
				3'd0, 3'd4: s = SEL_TURN;
				3'd1, 3'd5: s = SEL_RGREEN;
				3'd2, 3'd6: s = SEL_AMBER;
				default:    s = SEL_ALLRED;
			endcase
		end else begin
			case (ph)
				3'd0, 3'd3: s = SEL_TURN;
				3'd1, 3'd4: s = SEL_NGREEN;
				3'd2, 3'd5: s = SEL_AMBER;
				default:    s = SEL_ALLRED;
			endcase
		end
		return s;
	endfunction

endpackage

>>> sv/tlseq_out_buf.sv
// Two-entry output buffer: result register plus skid stage.
module tlseq_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  tlseq_pkg::result_t  push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output tlseq_pkg::result_t  pop_data
);
	import tlseq_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    push;
	logic    pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && !skid_valid_q;
	assign pop        = main_valid_q && pop_ready;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;

	// occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

>>> sv/two_road_traffic_light_sequencer_unit.sv
// A tick request's result is registered in the output buffer before it is presented.
// Throughput: one tick request per cycle while the output buffer has room; the
// phase countdown, display and blink counters all update in the accepting cycle.
// A two-entry output buffer lets one further request in while a result waits.
// Reset: phase 0, normal mode, countdown at the turn duration, counters and
// lamps cleared, all timing registers at their default values.
module two_road_traffic_light_sequencer_unit #(
	parameter int COUNT_BITS = tlseq_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tlseq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlseq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               rush_request,
	input  logic                               view_east_west,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               lamp_red,
	output logic                               lamp_amber,
	output logic                               lamp_green,
	output logic [1:0]                         north_south_aspect,
	output logic [1:0]                         east_west_aspect,
	output logic [tlseq_pkg::PHASE_W-1:0]      phase_index,
	output logic                               rush_active
);
	import tlseq_pkg::*;

	localparam longint unsigned CD_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [COUNT_BITS-1:0] CD_RST =
		COUNT_BITS'((64'(TURN_TICKS_RST) > CD_MAX) ? CD_MAX : 64'(TURN_TICKS_RST));

	// timing registers
	logic [DUR_W-1:0]   turn_ticks_q;
	logic [DUR_W-1:0]   ngreen_ticks_q;
	logic [DUR_W-1:0]   rgreen_ticks_q;
	logic [DUR_W-1:0]   amber_ticks_q;
	logic [DUR_W-1:0]   allred_ticks_q;
	logic [BLINK_W-1:0] blink_period_q;
	logic [DISP_W-1:0]  disp_period_q;

	// sequencer state
	logic [PHASE_W-1:0]    phase_q;
	logic [COUNT_BITS-1:0] countdown_q;
	logic                  mode_q;
	logic [DISP_W-1:0]     disp_count_q;
	logic [BLINK_W-1:0]    blink_count_q;
	logic [2:0]            lamps_q;

	logic                  accept;
	logic                  cd_expired;
	logic                  wrap;
	logic                  mode_next;
	logic [PHASE_W-1:0]    phase_next;
	dur_sel_t              sel;
	logic [DUR_W-1:0]      dur_raw;
	logic [DUR_W-1:0]      dur_min1;
	logic [COUNT_BITS-1:0] dur_load;
	logic [COUNT_BITS-1:0] countdown_next;
	aspect_t               ns_asp;
	aspect_t               ew_asp;
	aspect_t               viewed;
	logic [DISP_W-1:0]     disp_per;
	logic [DISP_W-1:0]     disp_inc;
	logic                  disp_hit;
	logic [DISP_W-1:0]     disp_count_next;
	logic [BLINK_W-1:0]    blink_per;
	logic [BLINK_W-1:0]    blink_inc;
	logic                  blink_hit;
	logic [BLINK_W-1:0]    blink_count_next;
	logic [2:0]            lamps_disp;
	logic [2:0]            lamps_next;
	result_t               res;
	result_t               res_out;
	logic                  buf_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = buf_ready;
	assign accept    = in_valid && buf_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_ticks_q   <= TURN_TICKS_RST;
			ngreen_ticks_q <= NGREEN_TICKS_RST;
			rgreen_ticks_q <= RGREEN_TICKS_RST;
			amber_ticks_q  <= AMBER_TICKS_RST;
			allred_ticks_q <= ALLRED_TICKS_RST;
			blink_period_q <= BLINK_PERIOD_RST;
			disp_period_q  <= DISP_PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TURN_TICKS:   turn_ticks_q   <= cfg_data;
				CFG_NGREEN_TICKS: ngreen_ticks_q <= cfg_data;
				CFG_RGREEN_TICKS: rgreen_ticks_q <= cfg_data;
				CFG_AMBER_TICKS:  amber_ticks_q  <= cfg_data;
				CFG_ALLRED_TICKS: allred_ticks_q <= cfg_data;
				CFG_BLINK_PERIOD: blink_period_q <= cfg_data[BLINK_W-1:0];
				CFG_DISP_PERIOD:  disp_period_q  <= cfg_data[DISP_W-1:0];
				default: ;
			endcase
		end
	end

	// phase advance
	always_comb begin
		cd_expired = (countdown_q[COUNT_BITS-1:1] == '0);
		wrap       = phase_q >= (mode_q ? LAST_PHASE_RUSH : LAST_PHASE_NORMAL);
		mode_next  = mode_q;
		phase_next = phase_q;
		if (cd_expired) begin
			if (wrap) begin
				phase_next = '0;
				mode_next  = rush_request;
			end else begin
				phase_next = phase_q + PHASE_W'(1);
			end
		end
		sel = dur_select(mode_next, phase_next);
	end

	// duration of the phase being entered
	always_comb begin
		case (sel)
			SEL_TURN:   dur_raw = turn_ticks_q;
			SEL_NGREEN: dur_raw = ngreen_ticks_q;
			SEL_RGREEN: dur_raw = rgreen_ticks_q;
			SEL_AMBER:  dur_raw = amber_ticks_q;
			default:    dur_raw = allred_ticks_q;
		endcase
		dur_min1 = (dur_raw == '0) ? DUR_W'(1) : dur_raw;
	end

	// saturate to the countdown width
	generate
		if (COUNT_BITS >= DUR_W) begin : g_dur_wide
			assign dur_load = COUNT_BITS'(dur_min1);
		end else begin : g_dur_narrow
			assign dur_load = (|dur_min1[DUR_W-1:COUNT_BITS]) ? '1 : dur_min1[COUNT_BITS-1:0];
		end
	endgenerate

	assign countdown_next = cd_expired ? dur_load : (countdown_q - COUNT_BITS'(1));

	// aspects and lamp update
	always_comb begin
		ns_asp = ns_aspect(mode_next, phase_next);
		ew_asp = ew_aspect(phase_next);
		viewed = view_east_west ? ew_asp : ns_asp;

		disp_per        = (disp_period_q == '0) ? DISP_W'(1) : disp_period_q;
		disp_inc        = disp_count_q + DISP_W'(1);
		disp_hit        = disp_inc >= disp_per;
		disp_count_next = disp_hit ? '0 : disp_inc;

		lamps_disp = lamps_q;
		if (disp_hit) begin
			case (viewed)
				ASP_RED:   lamps_disp = 3'b001;
				ASP_AMBER: lamps_disp = 3'b010;
				ASP_GREEN: lamps_disp = 3'b100;
				default:   lamps_disp = lamps_q;
			endcase
		end

		blink_per        = (blink_period_q == '0) ? BLINK_W'(1) : blink_period_q;
		blink_inc        = blink_count_q + BLINK_W'(1);
		blink_hit        = blink_inc >= blink_per;
		blink_count_next = blink_hit ? '0 : blink_inc;

		lamps_next = lamps_disp;
		if (blink_hit && viewed == ASP_TURN) begin
			lamps_next = {~lamps_disp[2], 2'b00};
		end

		res.lamp_red           = lamps_next[0];
		res.lamp_amber         = lamps_next[1];
		res.lamp_green         = lamps_next[2];
		res.north_south_aspect = ns_asp;
		res.east_west_aspect   = ew_asp;
		res.phase_index        = phase_next;
		res.rush_active        = mode_next;
	end

	// state registers, stepped once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			countdown_q   <= CD_RST;
			mode_q        <= 1'b0;
			disp_count_q  <= '0;
			blink_count_q <= '0;
			lamps_q       <= '0;
		end else if (accept) begin
			phase_q       <= phase_next;
			countdown_q   <= countdown_next;
			mode_q        <= mode_next;
			disp_count_q  <= disp_count_next;
			blink_count_q <= blink_count_next;
			lamps_q       <= lamps_next;
		end
	end

	// result register and skid stage
	tlseq_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (buf_ready),
		.push_data  (res),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (res_out)
	);

	assign lamp_red           = res_out.lamp_red;
	assign lamp_amber         = res_out.lamp_amber;
	assign lamp_green         = res_out.lamp_green;
	assign north_south_aspect = res_out.north_south_aspect;
	assign east_west_aspect   = res_out.east_west_aspect;
	assign phase_index        = res_out.phase_index;
	assign rush_active        = res_out.rush_active;

endmodule
